FILE: rtl/core/ahpf_pkg.sv
// Shared types, constants and helper functions of the ASCII hex packet framer.
package ahpf_pkg;

  localparam int unsigned HEAD_BYTES_DEF  = 2;
  localparam int unsigned TAIL_BYTES_DEF  = 2;
  localparam int unsigned MAX_PAYLOAD_DEF = 1400;
  localparam int unsigned FIFO_DEPTH_DEF  = 4;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PATTERN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PATTERN = CFG_IDX_W'(1);

  localparam int unsigned HEX_CHARS     = 16;
  localparam logic [15:0] LEN_OFFSET    = 16'd14;
  localparam logic [7:0]  HEX_NUM_BASE  = 8'h30;  // '0'
  localparam logic [7:0]  HEX_ALPHA_BASE = 8'h57; // 'a' - 10
  localparam logic [3:0]  NIB_MASK      = 4'hf;

  // One command handed from the front to the back end.
  typedef struct packed {
    logic        err;
    logic        hdr;
    logic        dat;
    logic        trl;
    logic [7:0]  data;
    logic [15:0] len_field;
    logic [15:0] type_code;
    logic [15:0] plen;
    logic [7:0]  total;
    logic [7:0]  seq;
    logic [7:0]  csum;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NIB_MASK;
    if (n < 4'd10) begin
      return HEX_NUM_BASE + {4'h0, n};
    end else begin
      return HEX_ALPHA_BASE + {4'h0, n};
    end
  endfunction

endpackage

FILE: rtl/core/ahpf_if.sv
// Channel interfaces of the framer: input items, result bytes and register writes.
interface ahpf_in_if import ahpf_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] payload_length;
  logic [15:0] type_code;
  logic [7:0]  packet_total;
  logic [7:0]  packet_sequence;

  modport source (output valid, data_byte, payload_length, type_code, packet_total,
                  packet_sequence, input ready);
  modport sink (input valid, data_byte, payload_length, type_code, packet_total,
                packet_sequence, output ready);
endinterface

interface ahpf_out_if import ahpf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       length_error;

  modport source (output valid, out_byte, frame_end, length_error, input ready);
  modport sink (input valid, out_byte, frame_end, length_error, output ready);
endinterface

interface ahpf_cfg_if import ahpf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/core/ascii_hex_packet_framer.sv
// Top level of the ASCII hex packet framer: register port, front end, queue and back end.
//
//  Channel | Direction | Payload                                        | Transaction
//  in_i    | sink      | data_byte, payload_length, type_code, totals   | one payload item
//  out_o   | source    | out_byte, frame_end, length_error              | one frame byte
//  cfg_i   | sink      | reg_index, wdata                               | one register write
//
// Payload bytes in the middle of a packet flow at one per cycle while out_o is ready; a byte
// is held in the command queue and then in the output byte register before out_o shows it.
// The first item of a packet yields HeadBytes + 16 bytes and the last one 2 + TailBytes more,
// one per cycle, paced by the single output byte register of the back end.
// The command queue (FifoDepth entries) lets input items keep arriving during those bursts.
// Reset clears packet progress, checksum and pattern registers to zero and empties the queue.
// A stalled output holds its byte; the input stalls only when the queue is full.
module ascii_hex_packet_framer import ahpf_pkg::*; #(
  parameter int unsigned HeadBytes  = HEAD_BYTES_DEF,
  parameter int unsigned TailBytes  = TAIL_BYTES_DEF,
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF,
  parameter int unsigned FifoDepth  = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ahpf_in_if.sink   in_i,
  ahpf_out_if.source out_o,
  ahpf_cfg_if.sink  cfg_i
);

  logic [CFG_DATA_W-1:0] head_pattern_q, tail_pattern_q;
  logic                  push, pop, full, empty;
  cmd_t                  wr_cmd, rd_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pattern_q <= '0;
      tail_pattern_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == CFG_HEAD_PATTERN) begin
        head_pattern_q <= cfg_i.wdata;
      end else if (cfg_i.reg_index == CFG_TAIL_PATTERN) begin
        tail_pattern_q <= cfg_i.wdata;
      end
    end
  end

  ahpf_front #(
    .MaxPayload (MaxPayload)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (wr_cmd)
  );

  ahpf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_cmd),
    .pop_i   (pop),
    .rdata_o (rd_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  ahpf_back #(
    .HeadBytes (HeadBytes),
    .TailBytes (TailBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (rd_cmd),
    .empty_i        (empty),
    .pop_o          (pop),
    .head_pattern_i (head_pattern_q),
    .tail_pattern_i (tail_pattern_q),
    .out_o          (out_o)
  );

endmodule

FILE: rtl/core/ahpf_front.sv
// Front end: accepts input items, tracks packet progress and checksum, issues commands.
module ahpf_front import ahpf_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ahpf_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [15:0] bytes_seen_q, bytes_seen_d;
  logic [7:0]  running_xor_q, running_xor_d;
  logic        start;
  logic        closes;
  logic [15:0] seen_inc;
  logic [7:0]  hdr_xor;
  logic [7:0]  acc_xor;

  function automatic logic [7:0] field_xor(input logic [47:0] word);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < 12; i++) begin
      x = x ^ hex_char(word[4*i +: 4]);
    end
    return x;
  endfunction

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign start    = (bytes_seen_q == 16'd0);
  assign seen_inc = bytes_seen_q + 16'd1;
  assign hdr_xor  = field_xor({in_i.type_code, in_i.payload_length,
                               in_i.packet_total, in_i.packet_sequence});
  assign acc_xor  = (start ? hdr_xor : running_xor_q) ^ in_i.data_byte;
  assign closes   = (seen_inc >= in_i.payload_length);

  always_comb begin
    cmd_o.err       = (in_i.payload_length > 16'(MaxPayload));
    cmd_o.hdr       = 1'b0;
    cmd_o.dat       = 1'b0;
    cmd_o.trl       = 1'b0;
    cmd_o.data      = in_i.data_byte;
    cmd_o.len_field = in_i.payload_length + LEN_OFFSET;
    cmd_o.type_code = in_i.type_code;
    cmd_o.plen      = in_i.payload_length;
    cmd_o.total     = in_i.packet_total;
    cmd_o.seq       = in_i.packet_sequence;
    cmd_o.csum      = acc_xor;
    bytes_seen_d    = 16'd0;
    running_xor_d   = 8'h00;
    if (cmd_o.err) begin
      cmd_o.csum = 8'h00;
    end else if (start && (in_i.payload_length == 16'd0)) begin
      // An empty packet carries the whole frame on this one item.
      cmd_o.hdr  = 1'b1;
      cmd_o.trl  = 1'b1;
      cmd_o.csum = hdr_xor;
    end else begin
      cmd_o.hdr = start;
      cmd_o.dat = 1'b1;
      cmd_o.trl = closes;
      if (!closes) begin
        bytes_seen_d  = seen_inc;
        running_xor_d = acc_xor;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q  <= 16'd0;
      running_xor_q <= 8'h00;
    end else if (push_o) begin
      bytes_seen_q  <= bytes_seen_d;
      running_xor_q <= running_xor_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_seen_q <= 16'(MaxPayload))
    else $error("packet progress passed the payload limit");

endmodule

FILE: rtl/core/ahpf_fifo.sv
// Short command queue between the front end and the byte sequencer.
module ahpf_fifo import ahpf_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end else begin
      return p + PtrW'(1);
    end
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("command pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("command popped from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue fill count out of range");

endmodule

FILE: rtl/core/ahpf_back.sv
// Back end: expands each command into frame bytes and holds them in an output register.
module ahpf_back import ahpf_pkg::*; #(
  parameter int unsigned HeadBytes = HEAD_BYTES_DEF,
  parameter int unsigned TailBytes = TAIL_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  logic [CFG_DATA_W-1:0] head_pattern_i,
  input  logic [CFG_DATA_W-1:0] tail_pattern_i,
  ahpf_out_if.source            out_o
);

  localparam int unsigned MaxCnt0 = (HeadBytes > HEX_CHARS) ? HeadBytes : HEX_CHARS;
  localparam int unsigned MaxCnt  = (TailBytes > MaxCnt0) ? TailBytes : MaxCnt0;
  localparam int unsigned CntW    = $clog2(MaxCnt);

  typedef enum logic [5:0] {
    PhErr  = 6'b000001,
    PhHead = 6'b000010,
    PhHex  = 6'b000100,
    PhData = 6'b001000,
    PhSum  = 6'b010000,
    PhTail = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d, cur_ph, first_ph, next_ph;
  logic            fresh_q, fresh_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last, done, emit, can_emit;
  logic [7:0]      byte_c;
  logic [3:0]      hex_nib;
  logic [63:0]     hex_word;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       frame_end_q;
  logic       length_error_q;

  // Only the two low bytes of a pattern exist; the rest read as zero.
  function automatic logic [7:0] pattern_byte(input logic [CFG_DATA_W-1:0] pat,
                                              input logic [CntW-1:0] idx);
    if (idx == CntW'(0)) begin
      return pat[7:0];
    end else if (idx == CntW'(1)) begin
      return pat[15:8];
    end else begin
      return 8'h00;
    end
  endfunction

  assign hex_word = {cmd_i.len_field, cmd_i.type_code, cmd_i.plen, cmd_i.total, cmd_i.seq};
  assign hex_nib  = 4'(hex_word >> {4'd15 - cnt_q[3:0], 2'b00});

  always_comb begin
    if (cmd_i.err) begin
      first_ph = PhErr;
    end else if (cmd_i.hdr) begin
      first_ph = PhHead;
    end else begin
      first_ph = PhData;
    end
  end

  assign cur_ph = fresh_q ? first_ph : phase_q;

  always_comb begin
    byte_c  = 8'h00;
    last    = 1'b1;
    next_ph = cur_ph;
    done    = 1'b0;
    case (cur_ph)
      PhErr: begin
        done = 1'b1;
      end
      PhHead: begin
        byte_c  = pattern_byte(head_pattern_i, cnt_q);
        last    = (cnt_q == CntW'(HeadBytes - 1));
        next_ph = PhHex;
      end
      PhHex: begin
        byte_c = hex_char(hex_nib);
        last   = (cnt_q == CntW'(HEX_CHARS - 1));
        if (cmd_i.dat) begin
          next_ph = PhData;
        end else if (cmd_i.trl) begin
          next_ph = PhSum;
        end else begin
          done = 1'b1;
        end
      end
      PhData: begin
        byte_c = cmd_i.data;
        if (cmd_i.trl) begin
          next_ph = PhSum;
        end else begin
          done = 1'b1;
        end
      end
      PhSum: begin
        byte_c  = (cnt_q == CntW'(0)) ? hex_char(cmd_i.csum[7:4]) : hex_char(cmd_i.csum[3:0]);
        last    = (cnt_q == CntW'(1));
        next_ph = PhTail;
      end
      PhTail: begin
        byte_c = pattern_byte(tail_pattern_i, cnt_q);
        last   = (cnt_q == CntW'(TailBytes - 1));
        done   = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign can_emit = !out_valid_q || out_o.ready;
  assign emit     = !empty_i && can_emit;
  assign pop_o    = emit && last && done;

  always_comb begin
    fresh_d = fresh_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (emit) begin
      if (last && done) begin
        fresh_d = 1'b1;
        phase_d = PhErr;
        cnt_d   = '0;
      end else if (last) begin
        fresh_d = 1'b0;
        phase_d = next_ph;
        cnt_d   = '0;
      end else begin
        fresh_d = 1'b0;
        phase_d = cur_ph;
        cnt_d   = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b1;
      phase_q     <= PhErr;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q     <= byte_c;
      frame_end_q    <= ((cur_ph == PhTail) && last) || (cur_ph == PhErr);
      length_error_q <= (cur_ph == PhErr);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.frame_end    = frame_end_q;
  assign out_o.length_error = length_error_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !fresh_q |-> !empty_i)
    else $error("command left the queue while its bytes were still being sent");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && length_error_q |-> frame_end_q && (out_byte_q == 8'h00))
    else $error("error result without frame end or with a nonzero byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && cmd_i.err |-> fresh_q)
    else $error("error command reached the sequencer in the middle of a command");

endmodule
